// ----- rtl/chte_pkg.sv -----
package chte_pkg;
   localparam int Buckets = 256;
   localparam int Entries = 256;
   localparam int KeyBytes = 8;
   localparam int BktW = $clog2(Buckets);
   localparam int EntW = $clog2(Entries);
   localparam int LinkW = EntW + 1;
   localparam int CntW = EntW + 1;
   localparam logic [31:0] FnvBasis = 32'd2166136261;
   localparam logic [31:0] FnvPrime = 32'd16777619;
   localparam logic [LinkW-1:0] NilLink = LinkW'(Entries);

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_GET    = 2'd2,
      REQ_CLEAR  = 2'd3
   } req_type_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_DUPLICATE = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_HASH, S_HEAD, S_HEADW, S_RDENT, S_CMP,
      S_POP, S_POPW, S_RESP
   } state_type;

   localparam logic [0:0] RegAllowOverwrite = 1'b0;
endpackage

// ----- rtl/chte_fnv.sv -----
module chte_fnv
   import chte_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] key,
   input  logic [3:0]  len,
   output logic        done,
   output logic [31:0] hash
);
   logic [31:0] h_ff, h_in;
   logic [3:0] i_ff, i_in;
   logic busy_ff, busy_in;
   logic [7:0] byte_sel;

   assign byte_sel = key[{i_ff[2:0], 3'b000} +: 8];
   assign hash = h_ff;
   assign done = busy_ff && (i_ff == len);

   always_comb begin
      h_in = h_ff;
      i_in = i_ff;
      busy_in = busy_ff;
      if (start) begin
         h_in = FnvBasis;
         i_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (i_ff == len) begin
            busy_in = 1'b0;
         end else begin
            h_in = (h_ff * FnvPrime) ^ {24'd0, byte_sel};
            i_in = i_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      h_ff <= h_in;
      i_ff <= i_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end
endmodule

// ----- rtl/chained_hash_table_engine_unit.sv -----
// channel   direction  ports
// request   in         req_valid/req_ready, req_type, req_key_bytes, req_key_length,
//                      req_value_handle
// response  out        rsp_valid/rsp_ready, rsp_status, rsp_value_out, rsp_entry_count
// csr       in         csr_psel/penable/pwrite/paddr/pwdata, csr_prdata, csr_pready
// One item at a time: the hash walks the key one byte at a time, then each chain
// entry visited is read and compared (one entry read port), plus head read/update.
// Clear and reset sweep the 256 bucket heads, one per cycle.
// A response waits in its register until taken; no new item until then.
module chained_hash_table_engine_unit
   import chte_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [63:0] req_key_bytes,
   input  logic [3:0]  req_key_length,
   input  logic [31:0] req_value_handle,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_value_out,
   output logic [8:0]  rsp_entry_count,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [0:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [LinkW-1:0] head_mem [Buckets];
   logic [63:0] key_mem [Entries];
   logic [3:0] klen_mem [Entries];
   logic [31:0] val_mem [Entries];
   logic [LinkW-1:0] next_mem [Entries];
   logic [EntW-1:0] free_mem [Entries];

   state_type state_ff, state_in;
   logic aow_ff;
   logic [1:0] op_ff;
   logic [63:0] key_ff;
   logic [3:0] len_ff;
   logic [31:0] val_ff;
   logic [BktW-1:0] bkt_ff, bkt_in;
   logic [LinkW-1:0] cur_ff, cur_in, prev_ff, prev_in;
   logic [CntW-1:0] top_ff, top_in, cnt_ff, cnt_in;
   logic [BktW:0] sweep_ff, sweep_in;
   logic [1:0] st_ff, st_in;
   logic [31:0] vout_ff, vout_in;
   logic rv_ff, rv_in;

   logic [LinkW-1:0] head_q;
   logic [63:0] key_q;
   logic [3:0] klen_q;
   logic [31:0] val_q;
   logic [LinkW-1:0] next_q;
   logic [EntW-1:0] free_q;

   logic head_we; logic [BktW-1:0] head_wa; logic [LinkW-1:0] head_wd;
   logic ent_we; logic [EntW-1:0] ent_wa;
   logic val_we; logic [31:0] val_wd;
   logic nxt_we; logic [EntW-1:0] nxt_wa; logic [LinkW-1:0] nxt_wd;
   logic free_we; logic [EntW-1:0] free_wa, free_wd;
   logic [EntW-1:0] ent_ra, free_ra;
   logic [BktW-1:0] head_ra;

   logic [3:0] len_c;
   logic [63:0] mask_c;
   logic hs_start, hs_done;
   logic [31:0] hs_hash;
   logic csr_wr;

   assign len_c = (req_key_length > 4'(KeyBytes)) ? 4'(KeyBytes) : req_key_length;
   always_comb begin
      for (int b = 0; b < 8; b++) mask_c[b*8 +: 8] = (4'(b) < len_c) ? 8'hFF : 8'h00;
   end

   chte_fnv u_fnv (
      .clock(clock), .reset(reset), .start(hs_start), .key(key_ff), .len(len_ff),
      .done(hs_done), .hash(hs_hash)
   );

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = {31'd0, aow_ff};
   assign req_ready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_status = st_ff;
   assign rsp_value_out = vout_ff;
   assign rsp_entry_count = cnt_ff;

   always_comb begin
      state_in = state_ff; bkt_in = bkt_ff; cur_in = cur_ff; prev_in = prev_ff;
      top_in = top_ff; cnt_in = cnt_ff; sweep_in = sweep_ff;
      st_in = st_ff; vout_in = vout_ff; rv_in = rv_ff;
      hs_start = 1'b0;
      head_we = 1'b0; head_wa = sweep_ff[BktW-1:0]; head_wd = NilLink;
      head_ra = bkt_ff;
      ent_we = 1'b0; ent_wa = free_q;
      val_we = 1'b0; val_wd = val_ff;
      nxt_we = 1'b0; nxt_wa = free_q; nxt_wd = head_q;
      free_we = 1'b0; free_wa = sweep_ff[EntW-1:0];
      free_wd = EntW'(Entries - 1) - sweep_ff[EntW-1:0];
      ent_ra = cur_ff[EntW-1:0];
      free_ra = EntW'(top_ff - CntW'(1));
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      case (state_ff)
         S_INIT: begin
            head_we = 1'b1;
            free_we = 1'b1;
            sweep_in = sweep_ff + (BktW+1)'(1);
            if (sweep_ff == (BktW+1)'(Buckets - 1)) begin
               state_in = S_IDLE;
               sweep_in = '0;
               top_in = CntW'(Entries);
               cnt_in = '0;
            end
         end
         S_IDLE: begin
            if (req_valid && req_ready) begin
               if (req_type == REQ_CLEAR) begin
                  state_in = S_INIT;
                  sweep_in = '0;
                  st_in = ST_OK; vout_in = '0;
                  rv_in = 1'b1;
                  cnt_in = '0;
               end else begin
                  state_in = S_HASH;
                  hs_start = 1'b1;
               end
            end
         end
         S_HASH: if (hs_done) begin
            bkt_in = hs_hash[BktW-1:0];
            state_in = S_HEAD;
         end
         S_HEAD: state_in = S_HEADW;
         S_HEADW: begin
            cur_in = head_q;
            prev_in = NilLink;
            state_in = S_RDENT;
         end
         S_RDENT: begin
            if (cur_ff[EntW]) begin
               if (op_ff == REQ_INSERT) begin
                  if (top_ff == '0) begin
                     st_in = ST_FULL; vout_in = '0; state_in = S_RESP;
                  end else state_in = S_POP;
               end else begin
                  st_in = ST_NOT_FOUND; vout_in = '0; state_in = S_RESP;
               end
            end else state_in = S_CMP;
         end
         S_CMP: begin
            if (klen_q == len_ff && key_q == key_ff) begin
               state_in = S_RESP;
               st_in = ST_OK; vout_in = '0;
               case (op_ff)
                  REQ_INSERT: begin
                     if (aow_ff) begin
                        val_we = 1'b1; ent_wa = cur_ff[EntW-1:0];
                     end else st_in = ST_DUPLICATE;
                  end
                  REQ_REMOVE: begin
                     vout_in = val_q;
                     if (prev_ff[EntW]) begin
                        head_we = 1'b1; head_wa = bkt_ff; head_wd = next_q;
                     end else begin
                        nxt_we = 1'b1; nxt_wa = prev_ff[EntW-1:0]; nxt_wd = next_q;
                     end
                     free_we = 1'b1; free_wa = top_ff[EntW-1:0];
                     free_wd = cur_ff[EntW-1:0];
                     top_in = top_ff + CntW'(1);
                     cnt_in = cnt_ff - CntW'(1);
                  end
                  default: vout_in = val_q;
               endcase
            end else begin
               prev_in = cur_ff;
               cur_in = next_q;
               state_in = S_RDENT;
            end
         end
         S_POP: state_in = S_POPW;
         S_POPW: begin
            ent_we = 1'b1; val_we = 1'b1; nxt_we = 1'b1;
            head_we = 1'b1; head_wa = bkt_ff; head_wd = {1'b0, free_q};
            top_in = top_ff - CntW'(1);
            cnt_in = cnt_ff + CntW'(1);
            st_in = ST_OK; vout_in = '0;
            state_in = S_RESP;
         end
         S_RESP: begin
            rv_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      head_q <= head_mem[head_ra];
      if (head_we) head_mem[head_wa] <= head_wd;
      key_q <= key_mem[ent_ra];
      klen_q <= klen_mem[ent_ra];
      val_q <= val_mem[ent_ra];
      next_q <= next_mem[ent_ra];
      if (ent_we) begin
         key_mem[ent_wa] <= key_ff;
         klen_mem[ent_wa] <= len_ff;
      end
      if (val_we) val_mem[ent_wa] <= val_wd;
      if (nxt_we) next_mem[nxt_wa] <= nxt_wd;
      free_q <= free_mem[free_ra];
      if (free_we) free_mem[free_wa] <= free_wd;
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff <= req_type;
         key_ff <= req_key_bytes & mask_c;
         len_ff <= len_c;
         val_ff <= req_value_handle;
      end
      bkt_ff <= bkt_in;
      cur_ff <= cur_in;
      prev_ff <= prev_in;
      st_ff <= st_in;
      vout_ff <= vout_in;
      if (reset) begin
         state_ff <= S_INIT;
         sweep_ff <= '0;
         top_ff <= CntW'(Entries);
         cnt_ff <= '0;
         rv_ff <= 1'b0;
         aow_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         top_ff <= top_in;
         cnt_ff <= cnt_in;
         rv_ff <= rv_in;
         if (csr_wr && csr_paddr == RegAllowOverwrite) aow_ff <= csr_pwdata[0];
      end
   end
endmodule
